[src/gitm_pkg.sv]
// Shared types, constants and arithmetic helpers of the grid texture mapper.
package gitm_pkg;

  // Default geometry
  localparam int BLOCKS_PER_SIDE_DEF   = 32;
  localparam int TEXTURE_SIDE_BITS_DEF = 7;

  // Block is always 8x8 pixels
  localparam int BLOCK_SIDE = 8;
  localparam int BLK_BITS   = 3;

  // Widest addresses over the parameter ranges (texture side 2^10, grid 129x129)
  localparam int TEX_AW_MAX  = 20;
  localparam int GRID_AW_MAX = 15;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Input opcodes
  localparam logic [1:0] OP_TEXEL  = 2'd0;
  localparam logic [1:0] OP_NODE   = 2'd1;
  localparam logic [1:0] OP_RENDER = 2'd2;

  // Register map
  localparam int         PADDR_W        = 2;
  localparam logic [1:0] CFG_SEAM_LIMIT = 2'd0;
  localparam logic [15:0] SEAM_RESET    = 16'd100;

  typedef enum logic [1:0] {
    CMD_TEXEL,
    CMD_NODE,
    CMD_RENDER
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t               kind;
    logic [TEX_AW_MAX-1:0]   tex_addr;
    logic [7:0]              tex_value;
    logic [GRID_AW_MAX-1:0]  grid_addr;
    logic [31:0]             angle;
    logic [31:0]             depth;
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_TL,
    S_RD_TR,
    S_RD_BL,
    S_RD_BR,
    S_CAP_BR,
    S_DIFF,
    S_STEP,
    S_ROW,
    S_PIX
  } back_state_t;

  // Signed divide by 8, rounding toward zero
  function automatic logic [31:0] div8(input logic [31:0] v);
    logic [31:0] t;
    t = v + {29'b0, {3{v[31]}}};
    return {{3{t[31]}}, t[31:3]};
  endfunction

  // Arithmetic shift right by 3
  function automatic logic [31:0] sar3(input logic [31:0] v);
    return {{3{v[31]}}, v[31:3]};
  endfunction

  // Keep cand unless it lies more than limit.0 (16.16) away from ref
  function automatic logic [31:0] seam_fix(input logic [31:0] cand,
                                           input logic [31:0] ref_val,
                                           input logic [15:0] limit);
    logic signed [33:0] d_fwd;
    logic signed [33:0] d_rev;
    logic signed [33:0] lim;
    d_fwd = $signed({{2{cand[31]}}, cand}) - $signed({{2{ref_val[31]}}, ref_val});
    d_rev = $signed({{2{ref_val[31]}}, ref_val}) - $signed({{2{cand[31]}}, cand});
    lim   = $signed({2'b00, limit, 16'b0});
    if ((d_fwd > lim) || (d_rev > lim)) return ref_val;
    return cand;
  endfunction

endpackage

[src/gitm_if.sv]
// Valid/ready channel interfaces for input items and pixel results.
interface gitm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [13:0] texel_address;
  logic [7:0]  texel_value;
  logic [5:0]  node_row;
  logic [5:0]  node_col;
  logic signed [31:0] node_angle;
  logic signed [31:0] node_depth;
  logic [4:0]  block_row;
  logic [4:0]  block_col;

  modport source (
    output valid, opcode, texel_address, texel_value, node_row, node_col,
           node_angle, node_depth, block_row, block_col,
    input  ready
  );
  modport sink (
    input  valid, opcode, texel_address, texel_value, node_row, node_col,
           node_angle, node_depth, block_row, block_col,
    output ready
  );
endinterface

interface gitm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_value;
  logic [2:0] pixel_row;
  logic [2:0] pixel_col;
  logic       last;

  modport source (
    output valid, pixel_value, pixel_row, pixel_col, last,
    input  ready
  );
  modport sink (
    input  valid, pixel_value, pixel_row, pixel_col, last,
    output ready
  );
endinterface

[src/gitm_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
module gitm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/gitm_front.sv]
// Front end: accepts input beats, decodes and range-checks them into commands.
module gitm_front
  import gitm_pkg::*;
#(
  parameter int BLOCKS_PER_SIDE   = BLOCKS_PER_SIDE_DEF,
  parameter int TEXTURE_SIDE_BITS = TEXTURE_SIDE_BITS_DEF
) (
  gitm_in_if.sink cmd_in,
  output logic    push_valid,
  input  logic    push_ready,
  output cmd_t    push_data
);

  localparam int TEX_AW    = 2 * TEXTURE_SIDE_BITS;
  localparam int GRID_SIDE = BLOCKS_PER_SIDE + 1;

  logic       keep;
  logic [7:0] blk_r;
  logic [7:0] blk_c;

  assign cmd_in.ready = push_ready;

  // Saturate the block position to the grid
  always_comb begin
    blk_r = {3'b0, cmd_in.block_row};
    blk_c = {3'b0, cmd_in.block_col};
    if (blk_r >= 8'(BLOCKS_PER_SIDE)) blk_r = 8'(BLOCKS_PER_SIDE - 1);
    if (blk_c >= 8'(BLOCKS_PER_SIDE)) blk_c = 8'(BLOCKS_PER_SIDE - 1);
  end

  // Classify the beat; node writes off the grid and the spare opcode are dropped
  always_comb begin
    keep                = 1'b0;
    push_data.kind      = CMD_TEXEL;
    push_data.tex_addr  = TEX_AW_MAX'(TEX_AW'(cmd_in.texel_address));
    push_data.tex_value = cmd_in.texel_value;
    push_data.grid_addr = '0;
    push_data.angle     = cmd_in.node_angle;
    push_data.depth     = cmd_in.node_depth;
    unique case (cmd_in.opcode)
      OP_TEXEL: begin
        keep = 1'b1;
      end
      OP_NODE: begin
        push_data.kind      = CMD_NODE;
        keep                = ({2'b0, cmd_in.node_row} < 8'(GRID_SIDE)) &&
                              ({2'b0, cmd_in.node_col} < 8'(GRID_SIDE));
        push_data.grid_addr = GRID_AW_MAX'(int'(cmd_in.node_row) * GRID_SIDE
                                           + int'(cmd_in.node_col));
      end
      OP_RENDER: begin
        push_data.kind      = CMD_RENDER;
        keep                = 1'b1;
        push_data.grid_addr = GRID_AW_MAX'(int'(blk_r) * GRID_SIDE + int'(blk_c));
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign push_valid = cmd_in.valid && keep;

endmodule

[src/gitm_queue.sv]
// Short command queue decoupling the front end from the render engine.
module gitm_queue
  import gitm_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_data,
  output logic pop_valid,
  input  logic pop,
  output cmd_t pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      count <= count + CW'(do_push) - CW'(do_pop);
    end
  end

endmodule

[src/gitm_back.sv]
// Back end: owns the texture and grid memories, executes writes and renders blocks.
module gitm_back
  import gitm_pkg::*;
#(
  parameter int BLOCKS_PER_SIDE   = BLOCKS_PER_SIDE_DEF,
  parameter int TEXTURE_SIDE_BITS = TEXTURE_SIDE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [15:0]       seam_limit,
  input  logic              q_valid,
  output logic              q_pop,
  input  cmd_t              q_data,
  gitm_out_if.source        pix_out
);

  localparam int TEX_AW     = 2 * TEXTURE_SIDE_BITS;
  localparam int TEX_DEPTH  = 1 << TEX_AW;
  localparam int GRID_SIDE  = BLOCKS_PER_SIDE + 1;
  localparam int GRID_DEPTH = GRID_SIDE * GRID_SIDE;
  localparam int GRID_AW    = $clog2(GRID_DEPTH);

  typedef struct packed {
    logic [7:0]          value;
    logic [BLK_BITS-1:0] row;
    logic [BLK_BITS-1:0] col;
    logic                last;
  } pix_t;

  back_state_t state, state_next;

  // Memory ports
  logic               tex_we;
  logic [TEX_AW-1:0]  tex_raddr;
  logic [7:0]         tex_rdata;
  logic               grid_we;
  logic [GRID_AW-1:0] grid_raddr;
  logic [31:0]        ang_rdata;
  logic [31:0]        dep_rdata;

  // Render datapath
  logic [GRID_AW-1:0] base;
  logic [31:0] a0, z0, a1, z1;       // left and right edge values
  logic [31:0] ab, zb, ab1, zb1;     // bottom corners, then edge steps
  logic [31:0] a, z, ai, zi;         // running position within a row
  logic [BLK_BITS-1:0] row, col;

  // Fetch tracking and output skid buffer
  logic                issue;
  logic                issue_ok;
  logic                pend;
  logic [BLK_BITS-1:0] pend_row, pend_col;
  logic                pend_last;
  pix_t                obuf [2];
  logic                ob_wr, ob_rd;
  logic [1:0]          occ;
  logic                out_pop;
  logic [1:0]          inflight;
  logic                row_end, blk_end;

  gitm_ram #(.WIDTH(8), .DEPTH(TEX_DEPTH)) u_tex (
    .clk   (clk),
    .we    (tex_we),
    .waddr (TEX_AW'(q_data.tex_addr)),
    .wdata (q_data.tex_value),
    .raddr (tex_raddr),
    .rdata (tex_rdata)
  );

  gitm_ram #(.WIDTH(32), .DEPTH(GRID_DEPTH)) u_angle (
    .clk   (clk),
    .we    (grid_we),
    .waddr (GRID_AW'(q_data.grid_addr)),
    .wdata (q_data.angle),
    .raddr (grid_raddr),
    .rdata (ang_rdata)
  );

  gitm_ram #(.WIDTH(32), .DEPTH(GRID_DEPTH)) u_depth (
    .clk   (clk),
    .we    (grid_we),
    .waddr (GRID_AW'(q_data.grid_addr)),
    .wdata (q_data.depth),
    .raddr (grid_raddr),
    .rdata (dep_rdata)
  );

  // Room for one more fetch if buffered plus pending stays within two
  assign out_pop  = pix_out.valid && pix_out.ready;
  assign inflight = occ + 2'(pend);
  assign issue_ok = (inflight < 2'd2) || out_pop;
  assign row_end  = (col == BLK_BITS'(BLOCK_SIDE - 1));
  assign blk_end  = row_end && (row == BLK_BITS'(BLOCK_SIDE - 1));

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (q_valid && (q_data.kind == CMD_RENDER)) state_next = S_RD_TL;
      end
      S_RD_TL:  state_next = S_RD_TR;
      S_RD_TR:  state_next = S_RD_BL;
      S_RD_BL:  state_next = S_RD_BR;
      S_RD_BR:  state_next = S_CAP_BR;
      S_CAP_BR: state_next = S_DIFF;
      S_DIFF:   state_next = S_STEP;
      S_STEP:   state_next = S_ROW;
      S_ROW:    state_next = S_PIX;
      S_PIX: begin
        if (issue_ok && row_end) state_next = blk_end ? S_IDLE : S_ROW;
      end
      default:  state_next = S_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    q_pop      = 1'b0;
    tex_we     = 1'b0;
    grid_we    = 1'b0;
    issue      = 1'b0;
    grid_raddr = base;
    tex_raddr  = {z[15 +: TEXTURE_SIDE_BITS], a[17 +: TEXTURE_SIDE_BITS]};
    unique case (state)
      S_IDLE: begin
        q_pop   = q_valid;
        tex_we  = q_valid && (q_data.kind == CMD_TEXEL);
        grid_we = q_valid && (q_data.kind == CMD_NODE);
      end
      S_RD_TL: grid_raddr = base;
      S_RD_TR: grid_raddr = base + GRID_AW'(1);
      S_RD_BL: grid_raddr = base + GRID_AW'(GRID_SIDE);
      S_RD_BR: grid_raddr = base + GRID_AW'(GRID_SIDE + 1);
      S_PIX:   issue      = issue_ok;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Corner fetch, edge setup and stepping
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        base <= GRID_AW'(q_data.grid_addr);
      end
      S_RD_TR: begin
        a0 <= ang_rdata;
        z0 <= dep_rdata;
      end
      S_RD_BL: begin
        a1 <= seam_fix(ang_rdata, a0, seam_limit);
        z1 <= dep_rdata;
      end
      S_RD_BR: begin
        ab <= seam_fix(ang_rdata, a0, seam_limit);
        zb <= dep_rdata;
      end
      S_CAP_BR: begin
        ab1 <= seam_fix(ang_rdata, a1, seam_limit);
        zb1 <= dep_rdata;
      end
      S_DIFF: begin
        ab  <= ab - a0;
        zb  <= zb - z0;
        ab1 <= ab1 - a1;
        zb1 <= zb1 - z1;
      end
      S_STEP: begin
        ab  <= div8(ab);
        zb  <= div8(zb);
        ab1 <= div8(ab1);
        zb1 <= div8(zb1);
      end
      S_ROW: begin
        ai <= sar3(a1 - a0);
        zi <= sar3(z1 - z0);
        a  <= a0;
        z  <= z0;
      end
      S_PIX: begin
        if (issue) begin
          a <= a + ai;
          z <= z + zi;
          if (row_end) begin
            a0 <= a0 + ab;
            z0 <= z0 + zb;
            a1 <= a1 + ab1;
            z1 <= z1 + zb1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Pixel position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      col <= '0;
    end else if (state == S_IDLE) begin
      row <= '0;
      col <= '0;
    end else if (issue) begin
      col <= col + 1'b1;
      if (row_end) row <= row + 1'b1;
    end
  end

  // Pending texel fetch
  always_ff @(posedge clk) begin
    if (rst) pend <= 1'b0;
    else     pend <= issue;
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      pend_row  <= row;
      pend_col  <= col;
      pend_last <= blk_end;
    end
  end

  // Two-entry output buffer
  always_ff @(posedge clk) begin
    if (pend) begin
      obuf[ob_wr] <= '{value: tex_rdata, row: pend_row, col: pend_col, last: pend_last};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ob_wr <= 1'b0;
      ob_rd <= 1'b0;
      occ   <= 2'd0;
    end else begin
      if (pend)    ob_wr <= ~ob_wr;
      if (out_pop) ob_rd <= ~ob_rd;
      occ <= occ + 2'(pend) - 2'(out_pop);
    end
  end

  assign pix_out.valid       = (occ != 2'd0);
  assign pix_out.pixel_value = obuf[ob_rd].value;
  assign pix_out.pixel_row   = obuf[ob_rd].row;
  assign pix_out.pixel_col   = obuf[ob_rd].col;
  assign pix_out.last        = obuf[ob_rd].last;

endmodule

[src/grid_interpolated_texture_mapper.sv]
// Top level of the grid-interpolated texture mapper: APB register, front, queue, back.
//
// cmd_in carries write and render beats (valid/ready, accepted when both are high).
// Texel writes and grid node writes are carried out by the render engine and
// give no result. A render beat names an 8x8 block and yields 64 pixel beats on
// pix_out, row-major, with last set on the 64th.
// A render reads its four corner nodes (one grid memory read per cycle), applies
// seam fixes and computes edge differences and edge steps, then per row one setup
// state and eight texel fetches, one per cycle from the texture memory port while
// the output buffer has room. A render starts when its beat leaves the four-entry
// command queue.
// The queue lets cmd_in keep accepting while a block is rendered; cmd_in stalls
// only when the queue is full. A stalled pix_out holds its beat; the engine
// pauses its fetches once its two-entry output buffer is full, losing nothing.
// Reset (rst, synchronous) empties the queue and buffer and sets seam_limit to
// 100; texture and grid contents are undefined until written.
// Register seam_limit lies at paddr 0; pready is always high.
module grid_interpolated_texture_mapper
  import gitm_pkg::*;
#(
  parameter int BLOCKS_PER_SIDE   = BLOCKS_PER_SIDE_DEF,
  parameter int TEXTURE_SIDE_BITS = TEXTURE_SIDE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  gitm_in_if.sink            cmd_in,
  gitm_out_if.source         pix_out,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [15:0] seam_limit;
  logic        push_valid;
  logic        push_ready;
  cmd_t        push_data;
  logic        q_valid;
  logic        q_pop;
  cmd_t        q_data;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr == CFG_SEAM_LIMIT) ? {16'b0, seam_limit} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      seam_limit <= SEAM_RESET;
    end else if (psel && penable && pwrite && pready && (paddr == CFG_SEAM_LIMIT)) begin
      seam_limit <= pwdata[15:0];
    end
  end

  gitm_front #(
    .BLOCKS_PER_SIDE   (BLOCKS_PER_SIDE),
    .TEXTURE_SIDE_BITS (TEXTURE_SIDE_BITS)
  ) u_front (
    .cmd_in     (cmd_in),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  gitm_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_data)
  );

  gitm_back #(
    .BLOCKS_PER_SIDE   (BLOCKS_PER_SIDE),
    .TEXTURE_SIDE_BITS (TEXTURE_SIDE_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .seam_limit (seam_limit),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_data     (q_data),
    .pix_out    (pix_out)
  );

endmodule

[test/tb_grid_interpolated_texture_mapper.sv]
// Self-checking testbench of the grid-interpolated texture mapper: random and directed beats.
module tb_grid_interpolated_texture_mapper;
  import gitm_pkg::*;

  localparam int NB       = BLOCKS_PER_SIDE_DEF;
  localparam int GRID     = NB + 1;
  localparam int TSB      = TEXTURE_SIDE_BITS_DEF;
  localparam int TEX_SIZE = 1 << (2 * TSB);
  localparam int SETTLE_CYCLES = 100;
  localparam int MAX_WAIT      = 13;

  localparam logic [1:0]         OP_SPARE  = 2'd3;
  localparam logic [PADDR_W-1:0] SEAM_ADDR = PADDR_W'(4 * CFG_SEAM_LIMIT);

  typedef struct {
    logic [1:0]  opcode;
    logic [13:0] texel_address;
    logic [7:0]  texel_value;
    logic [5:0]  node_row;
    logic [5:0]  node_col;
    logic [31:0] node_angle;
    logic [31:0] node_depth;
    logic [4:0]  block_row;
    logic [4:0]  block_col;
    bit          hold;      // present only once every pixel has come back
  } cmd_item_t;

  typedef struct packed {
    logic [7:0] value;
    logic [2:0] row;
    logic [2:0] col;
    logic       last;
  } pixel_t;

  logic clk = 1'b0;
  logic rst;
  logic psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  gitm_in_if  cmd_bus ();
  gitm_out_if pix_bus ();

  grid_interpolated_texture_mapper i_dut (
    .clk     (clk),
    .rst     (rst),
    .cmd_in  (cmd_bus),
    .pix_out (pix_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // Shadow state of the block
  logic [7:0]  tex_model   [TEX_SIZE];
  logic [31:0] angle_model [GRID*GRID];
  logic [31:0] depth_model [GRID*GRID];
  logic [15:0] seam_model;

  cmd_item_t pending_cmds[$];
  pixel_t    expected_pixels[$];
  cmd_item_t on_bus;
  int        errors;
  bit        drained;
  int        send_wait, take_wait;
  bit        send_quiet, take_quiet;

  // Corner keeps its angle unless it is more than seam_limit.0 away from its anchor
  function automatic logic [31:0] seam_pick(input logic [31:0] cand, input logic [31:0] anchor);
    longint d;
    d = longint'($signed(cand)) - longint'($signed(anchor));
    if (d < 0) d = -d;
    if (d > (longint'(seam_model) << 16)) return anchor;
    return cand;
  endfunction

  function automatic logic [31:0] toward_zero_div8(input logic [31:0] v);
    int s;
    s = v;
    return s / 8;
  endfunction

  // Bilinear stepping over one 8x8 block, pixels queued in row-major order
  function automatic void render_block(input logic [4:0] brow, input logic [4:0] bcol);
    int j, i, tl, tr, bl, br;
    logic [31:0] a_tl, a_bl, a_tr, a_br;
    logic [31:0] a_left, z_left, a_right, z_right;
    logic [31:0] a_left_inc, z_left_inc, a_right_inc, z_right_inc;
    logic [31:0] a, z, a_inc, z_inc, span;
    pixel_t px;
    j  = (brow >= NB) ? NB - 1 : brow;
    i  = (bcol >= NB) ? NB - 1 : bcol;
    tl = j * GRID + i;
    tr = tl + 1;
    bl = tl + GRID;
    br = bl + 1;
    a_tl = angle_model[tl];
    a_bl = seam_pick(angle_model[bl], a_tl);
    a_tr = seam_pick(angle_model[tr], a_tl);
    a_br = seam_pick(angle_model[br], a_tr);
    a_left      = a_tl;
    z_left      = depth_model[tl];
    a_right     = a_tr;
    z_right     = depth_model[tr];
    a_left_inc  = toward_zero_div8(a_bl - a_left);
    z_left_inc  = toward_zero_div8(depth_model[bl] - z_left);
    a_right_inc = toward_zero_div8(a_br - a_right);
    z_right_inc = toward_zero_div8(depth_model[br] - z_right);
    for (int r = 0; r < BLOCK_SIDE; r++) begin
      a     = a_left;
      z     = z_left;
      span  = a_right - a_left;
      a_inc = $signed(span) >>> 3;
      span  = z_right - z_left;
      z_inc = $signed(span) >>> 3;
      for (int c = 0; c < BLOCK_SIDE; c++) begin
        px.value = tex_model[{z[15 +: TSB], a[17 +: TSB]}];
        px.row   = r;
        px.col   = c;
        px.last  = (r == BLOCK_SIDE - 1) && (c == BLOCK_SIDE - 1);
        expected_pixels.push_back(px);
        a = a + a_inc;
        z = z + z_inc;
      end
      a_left  = a_left + a_left_inc;
      z_left  = z_left + z_left_inc;
      a_right = a_right + a_right_inc;
      z_right = z_right + z_right_inc;
    end
  endfunction

  // Update shadow state for one accepted beat
  function automatic void apply_command(input cmd_item_t it);
    int k;
    case (it.opcode)
      OP_TEXEL: tex_model[it.texel_address] = it.texel_value;
      OP_NODE: begin
        if (it.node_row < GRID && it.node_col < GRID) begin
          k = it.node_row * GRID + it.node_col;
          angle_model[k] = it.node_angle;
          depth_model[k] = it.node_depth;
        end
      end
      OP_RENDER: render_block(it.block_row, it.block_col);
      default: ;
    endcase
  endfunction

  // Item builders; fields the opcode does not use carry random bits
  function automatic cmd_item_t blank_item(input logic [1:0] op);
    cmd_item_t it;
    it.opcode        = op;
    it.texel_address = $urandom;
    it.texel_value   = $urandom;
    it.node_row      = $urandom;
    it.node_col      = $urandom;
    it.node_angle    = $urandom;
    it.node_depth    = $urandom;
    it.block_row     = $urandom;
    it.block_col     = $urandom;
    it.hold          = 1'b0;
    return it;
  endfunction

  function automatic cmd_item_t make_texel(input logic [13:0] addr, input logic [7:0] val);
    cmd_item_t it;
    it = blank_item(OP_TEXEL);
    it.texel_address = addr;
    it.texel_value   = val;
    return it;
  endfunction

  function automatic cmd_item_t make_node(input int r, input int c,
                                          input logic [31:0] ang, input logic [31:0] dep);
    cmd_item_t it;
    it = blank_item(OP_NODE);
    it.node_row   = r;
    it.node_col   = c;
    it.node_angle = ang;
    it.node_depth = dep;
    return it;
  endfunction

  function automatic cmd_item_t make_render(input int r, input int c);
    cmd_item_t it;
    it = blank_item(OP_RENDER);
    it.block_row = r;
    it.block_col = c;
    return it;
  endfunction

  // Smooth grid: about 4 texels of angle and 8 of depth per node, plus jitter
  function automatic logic [31:0] grid_angle(input int r, input int c);
    return c * 32'h0008_0000 + r * 32'h0001_0000 + $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
  endfunction

  function automatic logic [31:0] grid_depth(input int r, input int c);
    return r * 32'h0004_0000 + c * 32'h0000_8000 + $urandom_range(0, 32'h1_FFFF) - 32'h1_0000;
  endfunction

  function automatic cmd_item_t random_item();
    int pick, r, c;
    cmd_item_t it;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      it = make_render($urandom_range(0, NB - 1), $urandom_range(0, NB - 1));
    end else if (pick < 62) begin
      r = $urandom_range(0, GRID - 1);
      c = $urandom_range(0, GRID - 1);
      // node outside the grid now and then
      if ($urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1)) r = $urandom_range(GRID, 63);
        else c = $urandom_range(GRID, 63);
      end
      if ($urandom_range(0, 3) == 0) it = make_node(r, c, $urandom, $urandom);
      else it = make_node(r, c, grid_angle(r, c), grid_depth(r, c));
    end else if (pick < 95) begin
      it = make_texel($urandom, $urandom);
    end else begin
      it = blank_item(OP_SPARE);
    end
    return it;
  endfunction

  task automatic queue_random_items(input int count);
    cmd_item_t it;
    for (int k = 0; k < count; k++) begin
      it = random_item();
      it.hold = (k == count / 2);
      pending_cmds.push_back(it);
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || cmd_bus.valid || expected_pixels.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_seam_readback();
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= SEAM_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    if (prdata[15:0] !== seam_model) begin
      errors++;
      $display("%0t: seam_limit readback expected %0d, got %0d", $time, seam_model,
               prdata[15:0]);
    end
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_seam_limit(input logic [15:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SEAM_ADDR;
    pwdata  <= {16'h0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    seam_model = v;
    check_seam_readback();
    @(negedge clk);
  endtask

  function automatic void compare_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // Idle flag sampled away from the clock edge
  always @(negedge clk) drained = (expected_pixels.size() == 0);

  // Command driver
  always @(posedge clk) begin
    if (rst) begin
      cmd_bus.valid <= 1'b0;
      send_wait = 0;
    end else begin
      if (cmd_bus.valid && cmd_bus.ready) begin
        apply_command(on_bus);
        if ($urandom_range(0, 19) == 0) send_quiet = !send_quiet;
        send_wait = send_quiet ? 0 : $urandom_range(0, MAX_WAIT);
      end
      if (!cmd_bus.valid || cmd_bus.ready) begin
        if (send_wait > 0) begin
          send_wait--;
          cmd_bus.valid <= 1'b0;
        end else if (pending_cmds.size() != 0 && !(pending_cmds[0].hold && !drained)) begin
          on_bus = pending_cmds.pop_front();
          cmd_bus.opcode        <= on_bus.opcode;
          cmd_bus.texel_address <= on_bus.texel_address;
          cmd_bus.texel_value   <= on_bus.texel_value;
          cmd_bus.node_row      <= on_bus.node_row;
          cmd_bus.node_col      <= on_bus.node_col;
          cmd_bus.node_angle    <= on_bus.node_angle;
          cmd_bus.node_depth    <= on_bus.node_depth;
          cmd_bus.block_row     <= on_bus.block_row;
          cmd_bus.block_col     <= on_bus.block_col;
          cmd_bus.valid         <= 1'b1;
        end else begin
          cmd_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Pixel monitor with random backpressure
  always @(posedge clk) begin
    pixel_t want;
    if (rst) begin
      pix_bus.ready <= 1'b0;
      take_wait = 0;
    end else begin
      if (pix_bus.valid && pix_bus.ready) begin
        if (expected_pixels.size() == 0) begin
          errors++;
          $display("%0t: unexpected pixel beat: value %0d row %0d col %0d last %0d", $time,
                   pix_bus.pixel_value, pix_bus.pixel_row, pix_bus.pixel_col, pix_bus.last);
        end else begin
          want = expected_pixels.pop_front();
          compare_field("pixel_value", want.value, pix_bus.pixel_value);
          compare_field("pixel_row", want.row, pix_bus.pixel_row);
          compare_field("pixel_col", want.col, pix_bus.pixel_col);
          compare_field("last", want.last, pix_bus.last);
        end
        if ($urandom_range(0, 19) == 0) take_quiet = !take_quiet;
        take_wait = take_quiet ? 0 : $urandom_range(0, MAX_WAIT);
      end else if (take_wait > 0) begin
        take_wait--;
      end
      pix_bus.ready <= (take_wait == 0);
    end
  end

  // Stimulus sequence
  initial begin
    logic [31:0] base, lim;
    rst                   = 1'b1;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    cmd_bus.valid         = 1'b0;
    cmd_bus.opcode        = OP_TEXEL;
    cmd_bus.texel_address = '0;
    cmd_bus.texel_value   = '0;
    cmd_bus.node_row      = '0;
    cmd_bus.node_col      = '0;
    cmd_bus.node_angle    = '0;
    cmd_bus.node_depth    = '0;
    cmd_bus.block_row     = '0;
    cmd_bus.block_col     = '0;
    pix_bus.ready         = 1'b0;
    errors                = 0;
    send_quiet            = 1'b0;
    take_quiet            = 1'b0;
    seam_model            = SEAM_RESET;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    check_seam_readback();
    @(negedge clk);

    // Fill the whole texture and grid so that no render reads an unwritten entry
    for (int a = 0; a < TEX_SIZE; a++) pending_cmds.push_back(make_texel(a, $urandom));
    for (int r = 0; r < GRID; r++)
      for (int c = 0; c < GRID; c++)
        if ($urandom_range(0, 15) == 0)
          pending_cmds.push_back(make_node(r, c, $urandom, $urandom));
        else
          pending_cmds.push_back(make_node(r, c, grid_angle(r, c), grid_depth(r, c)));

    // Directed: field extremes, unused opcode, nodes outside the grid
    pending_cmds.push_back(make_texel(14'h3FFF, 8'hFF));
    pending_cmds.push_back(make_texel(14'h0000, 8'h00));
    pending_cmds.push_back(blank_item(OP_SPARE));
    pending_cmds.push_back(make_node(GRID, 5, $urandom, $urandom));
    pending_cmds.push_back(make_node(5, 63, $urandom, $urandom));
    pending_cmds.push_back(make_node(63, 63, $urandom, $urandom));
    // Seam compare at the reset limit: equal kept, one more replaced, both signs
    base = 32'h0100_0000;
    lim  = {SEAM_RESET, 16'h0};
    pending_cmds.push_back(make_node(0, 0, base, grid_depth(0, 0)));
    pending_cmds.push_back(make_node(0, 1, base + lim, grid_depth(0, 1)));
    pending_cmds.push_back(make_node(1, 0, base - lim - 1, grid_depth(1, 0)));
    pending_cmds.push_back(make_node(1, 1, base + lim + lim + 1, grid_depth(1, 1)));
    pending_cmds.push_back(make_render(0, 0));
    // Corner blocks and extreme node values
    pending_cmds.push_back(make_render(NB - 1, NB - 1));
    pending_cmds.push_back(make_render(0, NB - 1));
    pending_cmds.push_back(make_render(NB - 1, 0));
    pending_cmds.push_back(make_node(GRID - 1, GRID - 1, 32'h7FFF_FFFF, 32'h8000_0000));
    pending_cmds.push_back(make_node(GRID - 1, GRID - 2, 32'h8000_0000, 32'h7FFF_FFFF));
    pending_cmds.push_back(make_render(NB - 1, NB - 2));
    pending_cmds.push_back(make_render(NB - 1, NB - 1));
    pending_cmds[pending_cmds.size() - 1].hold = 1'b1;
    wait_idle();

    // Seam limit at zero: every angle jump is replaced
    set_seam_limit(16'd0);
    queue_random_items(40);
    wait_idle();

    // Seam limit at maximum: wrapping differences and truncation of negative steps
    set_seam_limit(16'hFFFF);
    pending_cmds.push_back(make_node(10, 10, 32'h8000_0000, 32'h8000_0000));
    pending_cmds.push_back(make_node(10, 11, 32'h7FFF_0000, 32'h0000_0000));
    pending_cmds.push_back(make_node(11, 10, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    pending_cmds.push_back(make_node(11, 11, 32'h0000_0000, 32'hFFFF_FFF3));
    pending_cmds.push_back(make_render(10, 10));
    queue_random_items(40);
    wait_idle();

    // Random limit
    set_seam_limit($urandom_range(1, 16'hFFFE));
    queue_random_items(50);
    wait_idle();

    if (errors == 0)
      $display("grid_interpolated_texture_mapper: match");
    else
      $display("grid_interpolated_texture_mapper: mismatch");
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("grid_interpolated_texture_mapper: mismatch");
    $finish;
  end

endmodule
